@@ sv/ddce_pkg.sv @@
// ddce_pkg: shared widths, request and control-bit codes, scaling constants
// and the structs passed between the stages of the dds command encoder.
// No dependencies.
`timescale 1ns / 1ps

package ddce_pkg;

    localparam int NUM_CHANNELS = 2;

    localparam int REQ_W   = 3;
    localparam int FREQ_W  = 24;
    localparam int PHASE_W = 9;
    localparam int SHAPE_W = 2;
    localparam int WORD_W  = 16;
    localparam int MASK_W  = 2;
    localparam int WAVE_W  = 2;
    localparam int TW_W    = 28;
    localparam int HALF_W  = 14;
    localparam int PW_W    = 12;
    localparam int MAX_RES = 3;
    localparam int CNT_W   = 2;

    localparam logic [REQ_W-1:0] REQ_RESET     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SET_FREQ  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SET_PHASE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SET_WAVE  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_QUERY     = 3'd4;

    localparam logic [SHAPE_W-1:0] SHAPE_SINE     = 2'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 2'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = 2'd2;
    localparam logic [SHAPE_W-1:0] SHAPE_KEEP     = 2'd3;

    localparam logic [WAVE_W-1:0] WAVE_SINE     = 2'd0;
    localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 2'd1;
    localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 2'd2;

    localparam logic [WORD_W-1:0] CTL_B28     = 16'h2000;
    localparam logic [WORD_W-1:0] CTL_RESET   = 16'h0100;
    localparam logic [WORD_W-1:0] CTL_OPBITEN = 16'h0020;
    localparam logic [WORD_W-1:0] CTL_DIV2    = 16'h0008;
    localparam logic [WORD_W-1:0] CTL_MODE    = 16'h0002;
    localparam logic [WORD_W-1:0] ADDR_FREQ0  = 16'h4000;
    localparam logic [WORD_W-1:0] ADDR_PHASE0 = 16'hC000;

    // tuning word = floor(hz * 2^FREQ_SHIFT / FREQ_DIV), via reciprocal
    localparam int FREQ_SHIFT       = 14;
    localparam int FREQ_DIV         = 1000;
    localparam int FREQ_RECIP_SHIFT = 24;
    localparam int FREQ_RECIP_W     = 29;
    localparam logic [FREQ_RECIP_W-1:0] FREQ_RECIP =
        FREQ_RECIP_W'((64'd1 << (FREQ_SHIFT + FREQ_RECIP_SHIFT)) / FREQ_DIV);
    localparam int FREQ_PROD_W = FREQ_W + FREQ_RECIP_W;
    localparam int FREQ_Q_W    = FREQ_PROD_W - FREQ_RECIP_SHIFT;
    localparam int FREQ_NUM_W  = FREQ_W + FREQ_SHIFT;

    // phase word = floor(deg * 2^PHASE_SHIFT / PHASE_DIV), via reciprocal
    localparam int PHASE_SHIFT       = 9;
    localparam int PHASE_DIV         = 45;
    localparam int PHASE_RECIP_SHIFT = 9;
    localparam int PHASE_RECIP_W     = 13;
    localparam logic [PHASE_RECIP_W-1:0] PHASE_RECIP =
        PHASE_RECIP_W'((64'd1 << (PHASE_SHIFT + PHASE_RECIP_SHIFT)) / PHASE_DIV);
    localparam int PHASE_PROD_W = PHASE_W + PHASE_RECIP_W;
    localparam int PHASE_Q_W    = PHASE_PROD_W - PHASE_RECIP_SHIFT;
    localparam int PHASE_NUM_W  = PHASE_W + PHASE_SHIFT;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic               channel;
        logic               hold_reset;
        logic [FREQ_W-1:0]  frequency_hz;
        logic [PHASE_W-1:0] phase_degrees;
        logic [SHAPE_W-1:0] wave_shape;
    } t_req;

    typedef struct packed {
        t_req                    req;
        logic [FREQ_PROD_W-1:0]  freq_prod;
        logic [PHASE_PROD_W-1:0] phase_prod;
    } t_scaled;

    typedef struct packed {
        logic [CNT_W-1:0]                count;
        logic [MAX_RES-1:0][WORD_W-1:0]  words;
        logic [MASK_W-1:0]               mask;
        logic                            word_valid;
        logic [FREQ_W-1:0]               frequency;
        logic [WAVE_W-1:0]               wave;
    } t_res;

    function automatic logic [WAVE_W-1:0] shape_of(input logic [WORD_W-1:0] ctl);
        logic [WAVE_W-1:0] w;
        if ((ctl & CTL_MODE) != '0) begin
            w = WAVE_TRIANGLE;
        end else if ((ctl & (CTL_OPBITEN | CTL_DIV2)) != '0) begin
            w = WAVE_SQUARE;
        end else begin
            w = WAVE_SINE;
        end
        return w;
    endfunction

endpackage

@@ sv/ddce_scale.sv @@
// ddce_scale: input register and registered reciprocal products for the
// frequency and phase scaling. Depends on ddce_pkg.
`timescale 1ns / 1ps

module ddce_scale (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ddce_pkg::t_req    i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output ddce_pkg::t_scaled o_scaled
);

    logic              r_v0;
    logic              n_v0;
    logic              r_v1;
    logic              n_v1;
    ddce_pkg::t_req    r_req;
    ddce_pkg::t_scaled r_sc;
    ddce_pkg::t_scaled n_sc;
    logic              s1_free;

    assign s1_free = !r_v1 || i_ready;
    assign o_ready = !r_v0 || s1_free;
    assign o_valid = r_v1;
    assign o_scaled = r_sc;

    always_comb begin
        n_v0 = o_ready ? i_valid : r_v0;
        n_v1 = s1_free ? r_v0 : r_v1;
        n_sc.req        = r_req;
        n_sc.freq_prod  = ddce_pkg::FREQ_PROD_W'(r_req.frequency_hz)
                          * ddce_pkg::FREQ_PROD_W'(ddce_pkg::FREQ_RECIP);
        n_sc.phase_prod = ddce_pkg::PHASE_PROD_W'(r_req.phase_degrees)
                          * ddce_pkg::PHASE_PROD_W'(ddce_pkg::PHASE_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
        if (s1_free && r_v0) begin
            r_sc <= n_sc;
        end
    end

endmodule

@@ sv/ddce_core.sv @@
// ddce_core: quotient correction, channel shadow registers and command word
// assembly for one request per cycle while the output buffer accepts a load. Depends on ddce_pkg.
`timescale 1ns / 1ps

module ddce_core #(
    parameter int NUM_CHANNELS = ddce_pkg::NUM_CHANNELS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ddce_pkg::t_scaled i_scaled,
    input  logic              i_load_ok,
    output logic              o_push,
    output ddce_pkg::t_res    o_res
);

    localparam logic HAS_CH1 = (NUM_CHANNELS > 1);

    logic [ddce_pkg::WORD_W-1:0]  r_ctl   [NUM_CHANNELS];
    logic [ddce_pkg::FREQ_W-1:0]  r_freq  [NUM_CHANNELS];
    logic [ddce_pkg::PHASE_W-1:0] r_phase [NUM_CHANNELS];

    ddce_pkg::t_req                   req;
    logic                             ch_ok;
    logic [ddce_pkg::WORD_W-1:0]      sel_ctl;
    logic [ddce_pkg::FREQ_W-1:0]      sel_freq;
    logic [ddce_pkg::FREQ_Q_W-1:0]    fq_est;
    logic [ddce_pkg::FREQ_NUM_W-1:0]  fnum;
    logic [ddce_pkg::FREQ_NUM_W-1:0]  frem;
    logic [ddce_pkg::FREQ_Q_W-1:0]    fq;
    logic [ddce_pkg::TW_W-1:0]        tw;
    logic [ddce_pkg::PHASE_Q_W-1:0]   pq_est;
    logic [ddce_pkg::PHASE_NUM_W-1:0] pnum;
    logic [ddce_pkg::PHASE_NUM_W-1:0] prem;
    logic [ddce_pkg::PHASE_Q_W-1:0]   pq;
    logic [ddce_pkg::WORD_W-1:0]      reset_ctl;
    logic [ddce_pkg::WORD_W-1:0]      wave_ctl;
    logic [ddce_pkg::MASK_W-1:0]      ch_mask;
    logic [ddce_pkg::MASK_W-1:0]      all_mask;
    logic                             upd;

    assign req      = i_scaled.req;
    assign ch_ok    = HAS_CH1 || !req.channel;
    assign ch_mask  = req.channel ? 2'b10 : 2'b01;
    assign all_mask = {HAS_CH1, 1'b1};

    always_comb begin
        sel_ctl  = '0;
        sel_freq = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (i == int'(req.channel)) begin
                sel_ctl  = r_ctl[i];
                sel_freq = r_freq[i];
            end
        end
    end

    // quotient estimate is low by at most one
    always_comb begin
        fq_est = i_scaled.freq_prod[ddce_pkg::FREQ_PROD_W-1:ddce_pkg::FREQ_RECIP_SHIFT];
        fnum   = {req.frequency_hz, {ddce_pkg::FREQ_SHIFT{1'b0}}};
        frem   = fnum - ddce_pkg::FREQ_NUM_W'(fq_est)
                 * ddce_pkg::FREQ_NUM_W'(ddce_pkg::FREQ_DIV);
        fq     = fq_est
                 + ddce_pkg::FREQ_Q_W'(frem >= ddce_pkg::FREQ_NUM_W'(ddce_pkg::FREQ_DIV));
        tw     = fq[ddce_pkg::TW_W-1:0];

        pq_est = i_scaled.phase_prod[ddce_pkg::PHASE_PROD_W-1:ddce_pkg::PHASE_RECIP_SHIFT];
        pnum   = {req.phase_degrees, {ddce_pkg::PHASE_SHIFT{1'b0}}};
        prem   = pnum - ddce_pkg::PHASE_NUM_W'(pq_est)
                 * ddce_pkg::PHASE_NUM_W'(ddce_pkg::PHASE_DIV);
        pq     = pq_est
                 + ddce_pkg::PHASE_Q_W'(prem >= ddce_pkg::PHASE_NUM_W'(ddce_pkg::PHASE_DIV));
    end

    always_comb begin
        reset_ctl = ddce_pkg::CTL_B28 | (req.hold_reset ? ddce_pkg::CTL_RESET : '0);
        unique case (req.wave_shape)
            ddce_pkg::SHAPE_SINE: begin
                wave_ctl = sel_ctl & ~(ddce_pkg::CTL_MODE | ddce_pkg::CTL_OPBITEN
                                       | ddce_pkg::CTL_DIV2);
            end
            ddce_pkg::SHAPE_TRIANGLE: begin
                wave_ctl = (sel_ctl & ~(ddce_pkg::CTL_OPBITEN | ddce_pkg::CTL_DIV2))
                           | ddce_pkg::CTL_MODE;
            end
            ddce_pkg::SHAPE_SQUARE: begin
                wave_ctl = (sel_ctl & ~ddce_pkg::CTL_MODE) | ddce_pkg::CTL_OPBITEN
                           | ddce_pkg::CTL_DIV2;
            end
            ddce_pkg::SHAPE_KEEP: begin
                wave_ctl = sel_ctl;
            end
        endcase
    end

    always_comb begin
        o_res            = '0;
        o_res.word_valid = 1'b1;
        o_res.mask       = ch_mask;
        o_res.frequency  = sel_freq;
        o_res.wave       = ddce_pkg::shape_of(sel_ctl);
        unique case (req.req_type)
            ddce_pkg::REQ_RESET: begin
                o_res.count    = 2'd1;
                o_res.words[0] = reset_ctl;
                o_res.mask     = all_mask;
                if (ch_ok) begin
                    o_res.wave = ddce_pkg::shape_of(reset_ctl);
                end else begin
                    o_res.frequency = '0;
                    o_res.wave      = ddce_pkg::WAVE_SINE;
                end
            end
            ddce_pkg::REQ_SET_FREQ: begin
                o_res.count     = ch_ok ? 2'd3 : 2'd0;
                o_res.words[0]  = sel_ctl;
                o_res.words[1]  = ddce_pkg::ADDR_FREQ0
                                  | ddce_pkg::WORD_W'(tw[ddce_pkg::HALF_W-1:0]);
                o_res.words[2]  = ddce_pkg::ADDR_FREQ0
                                  | ddce_pkg::WORD_W'(tw[ddce_pkg::TW_W-1:ddce_pkg::HALF_W]);
                o_res.frequency = req.frequency_hz;
            end
            ddce_pkg::REQ_SET_PHASE: begin
                o_res.count    = ch_ok ? 2'd1 : 2'd0;
                o_res.words[0] = ddce_pkg::ADDR_PHASE0
                                 | ddce_pkg::WORD_W'(pq[ddce_pkg::PW_W-1:0]);
            end
            ddce_pkg::REQ_SET_WAVE: begin
                o_res.count    = ch_ok ? 2'd1 : 2'd0;
                o_res.words[0] = wave_ctl;
                o_res.wave     = ddce_pkg::shape_of(wave_ctl);
            end
            ddce_pkg::REQ_QUERY: begin
                o_res.count      = ch_ok ? 2'd1 : 2'd0;
                o_res.mask       = '0;
                o_res.word_valid = 1'b0;
            end
            default: begin
                o_res.count = 2'd0;
            end
        endcase
    end

    assign o_ready = (o_res.count == 2'd0) || i_load_ok;
    assign o_push  = i_valid && (o_res.count != 2'd0) && i_load_ok;
    assign upd     = o_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_ctl[i]   <= '0;
                r_freq[i]  <= '0;
                r_phase[i] <= '0;
            end
        end else if (upd) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                if (req.req_type == ddce_pkg::REQ_RESET) begin
                    r_ctl[i] <= reset_ctl;
                end else if (i == int'(req.channel)) begin
                    if (req.req_type == ddce_pkg::REQ_SET_FREQ) begin
                        r_freq[i] <= req.frequency_hz;
                    end
                    if (req.req_type == ddce_pkg::REQ_SET_PHASE) begin
                        r_phase[i] <= req.phase_degrees;
                    end
                    if (req.req_type == ddce_pkg::REQ_SET_WAVE) begin
                        r_ctl[i] <= wave_ctl;
                    end
                end
            end
        end
    end

endmodule

@@ sv/ddce_out_buf.sv @@
// ddce_out_buf: result register holding up to three command words of one
// request and presenting them one transaction at a time. Depends on ddce_pkg.
`timescale 1ns / 1ps

module ddce_out_buf (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  ddce_pkg::t_res                i_res,
    output logic                          o_load_ok,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ddce_pkg::WORD_W-1:0]   o_spi_word,
    output logic [ddce_pkg::MASK_W-1:0]   o_select_mask,
    output logic                          o_word_valid,
    output logic                          o_last,
    output logic [ddce_pkg::FREQ_W-1:0]   o_channel_frequency,
    output logic [ddce_pkg::WAVE_W-1:0]   o_channel_wave
);

    logic [ddce_pkg::CNT_W-1:0] r_cnt;
    logic [ddce_pkg::CNT_W-1:0] n_cnt;
    ddce_pkg::t_res             r_res;
    logic                       pop;

    assign o_valid   = (r_cnt != 2'd0);
    assign pop       = o_valid && i_ready;
    assign o_load_ok = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_ready);
    assign o_last    = (r_cnt == 2'd1);

    assign o_spi_word          = r_res.words[0];
    assign o_select_mask       = r_res.mask;
    assign o_word_valid        = r_res.word_valid;
    assign o_channel_frequency = r_res.frequency;
    assign o_channel_wave      = r_res.wave;

    always_comb begin
        if (i_push) begin
            n_cnt = i_res.count;
        end else if (pop) begin
            n_cnt = r_cnt - 2'd1;
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end else if (pop) begin
            r_res.words[0] <= r_res.words[1];
            r_res.words[1] <= r_res.words[2];
        end
    end

endmodule

@@ sv/dual_dds_command_encoder_unit.sv @@
// dual_dds_command_encoder_unit: top level of the dds command encoder.
// path: input register, scaled-product register, then the output buffer register
// throughput: one request per cycle unless the result stalls; set-frequency gives
// three words (one per cycle while accepted), other requests one, ignored none
// reset: synchronous active low, clears the pipeline and result valid state
// and all channel shadow registers to zero
`timescale 1ns / 1ps

module dual_dds_command_encoder_unit #(
    parameter int NUM_CHANNELS = ddce_pkg::NUM_CHANNELS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ddce_pkg::REQ_W-1:0]    i_req_type,
    input  logic                          i_channel,
    input  logic                          i_hold_reset,
    input  logic [ddce_pkg::FREQ_W-1:0]   i_frequency_hz,
    input  logic [ddce_pkg::PHASE_W-1:0]  i_phase_degrees,
    input  logic [ddce_pkg::SHAPE_W-1:0]  i_wave_shape,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ddce_pkg::WORD_W-1:0]   o_spi_word,
    output logic [ddce_pkg::MASK_W-1:0]   o_select_mask,
    output logic                          o_word_valid,
    output logic                          o_last,
    output logic [ddce_pkg::FREQ_W-1:0]   o_channel_frequency,
    output logic [ddce_pkg::WAVE_W-1:0]   o_channel_wave
);

    ddce_pkg::t_req    in_req;
    ddce_pkg::t_scaled scaled;
    ddce_pkg::t_res    res;
    logic              sc_valid;
    logic              core_ready;
    logic              load_ok;
    logic              push;

    assign in_req.req_type      = i_req_type;
    assign in_req.channel       = i_channel;
    assign in_req.hold_reset    = i_hold_reset;
    assign in_req.frequency_hz  = i_frequency_hz;
    assign in_req.phase_degrees = i_phase_degrees;
    assign in_req.wave_shape    = i_wave_shape;

    ddce_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_req    (in_req),
        .o_valid  (sc_valid),
        .i_ready  (core_ready),
        .o_scaled (scaled)
    );

    ddce_core #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (sc_valid),
        .o_ready   (core_ready),
        .i_scaled  (scaled),
        .i_load_ok (load_ok),
        .o_push    (push),
        .o_res     (res)
    );

    ddce_out_buf u_out (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_push              (push),
        .i_res               (res),
        .o_load_ok           (load_ok),
        .o_valid             (o_out_valid),
        .i_ready             (i_out_ready),
        .o_spi_word          (o_spi_word),
        .o_select_mask       (o_select_mask),
        .o_word_valid        (o_word_valid),
        .o_last              (o_last),
        .o_channel_frequency (o_channel_frequency),
        .o_channel_wave      (o_channel_wave)
    );

endmodule

@@ sv/ddce_checker.sv @@
// ddce_checker: port-level assertions for dual_dds_command_encoder_unit,
// attached by the bind at the end of this file. Depends on ddce_pkg.
`timescale 1ns / 1ps

module ddce_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [ddce_pkg::WORD_W-1:0]   o_spi_word,
    input logic [ddce_pkg::MASK_W-1:0]   o_select_mask,
    input logic                          o_word_valid,
    input logic                          o_last,
    input logic [ddce_pkg::FREQ_W-1:0]   o_channel_frequency,
    input logic [ddce_pkg::WAVE_W-1:0]   o_channel_wave
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_spi_word)
        && $stable(o_select_mask) && $stable(o_word_valid) && $stable(o_last)
        && $stable(o_channel_frequency) && $stable(o_channel_wave))
        else $error("stalled result transaction changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_query_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_word_valid |-> o_last && (o_spi_word == '0)
        && (o_select_mask == '0))
        else $error("query result not a single empty word");

    a_burst_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last |=> o_out_valid)
        else $error("gap inside a multi-word request");

    a_word_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_word_valid |-> (o_select_mask != '0))
        else $error("command word with no chip select");

endmodule

bind dual_dds_command_encoder_unit ddce_checker u_ddce_checker (.*);
